[sv/rgb_to_yuv420_planar_core_macros.svh]
// Assertion macros shared by the RGB to YUV 4:2:0 planar core modules.
`ifndef RGB_TO_YUV420_PLANAR_CORE_MACROS_SVH
`define RGB_TO_YUV420_PLANAR_CORE_MACROS_SVH

// Clocked property, off while reset is asserted.
`define RYP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold at a clock edge.
`define RYP_ASSERT_NEVER(lbl, cond, msg) \
  `RYP_ASSERT(lbl, !(cond), msg)

`endif

[sv/ryp_pkg.sv]
// Package with types, constants and helpers of the RGB to YUV 4:2:0 planar core.
package ryp_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int unsigned SizeW   = 13;
  localparam int unsigned CntW    = 12;
  localparam int unsigned CompW   = 8;
  localparam int unsigned LAddrW  = 24;
  localparam int unsigned CAddrW  = 25;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned InDataW = 24;
  localparam int unsigned OutDataW = 104;

  localparam logic [SizeW-1:0] MaxWidthC  = SizeW'(MAX_WIDTH);
  localparam logic [SizeW-1:0] MaxHeightC = SizeW'(MAX_HEIGHT);
  localparam logic [SizeW-1:0] MinSize    = SizeW'(2);
  localparam logic [SizeW-1:0] WidthRst   = SizeW'(640);
  localparam logic [SizeW-1:0] HeightRst  = SizeW'(480);

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegFrameHeight = CfgIdxW'(1);

  // BT.601 integer coefficients.
  localparam logic [7:0] CoefYR = 8'd66;
  localparam logic [7:0] CoefYG = 8'd129;
  localparam logic [7:0] CoefYB = 8'd25;
  localparam logic [7:0] CoefUR = 8'd38;
  localparam logic [7:0] CoefUG = 8'd74;
  localparam logic [7:0] CoefUB = 8'd112;
  localparam logic [7:0] CoefVR = 8'd112;
  localparam logic [7:0] CoefVG = 8'd94;
  localparam logic [7:0] CoefVB = 8'd18;
  localparam logic [7:0] RoundC = 8'd128;
  localparam logic [7:0] LumaOffset = 8'd16;
  // Rounding plus the 128 chroma offset moved above the shift: 128 + 128*256.
  localparam logic [16:0] ChromaBias = 17'd32896;

  typedef struct packed {
    logic [SizeW-1:0]  width;
    logic [SizeW-1:0]  height;
    logic [CAddrW-1:0] plane_u;   // W*H, start of the U plane
    logic [CAddrW-1:0] plane_v;   // W*H + W*H/4, start of the V plane
  } cfg_t;

  typedef struct packed {
    logic [CompW-1:0] red;
    logic [CompW-1:0] green;
    logic [CompW-1:0] blue;
    logic [CntW-1:0]  col;
    logic [CntW-1:0]  row;
    logic             chroma;
    logic             last;
  } pix_t;

  typedef struct packed {
    logic [CompW-1:0]  luma;
    logic [LAddrW-1:0] luma_addr;
    logic              chroma_valid;
    logic [CompW-1:0]  chroma_u;
    logic [CompW-1:0]  chroma_v;
    logic [CAddrW-1:0] u_addr;
    logic [CAddrW-1:0] v_addr;
    logic              frame_last;
  } res_t;

  // Clear the low bit and clamp to [2, max].
  function automatic logic [SizeW-1:0] eff_size(logic [SizeW-1:0] raw,
                                                logic [SizeW-1:0] max);
    logic [SizeW-1:0] v;
    v = {raw[SizeW-1:1], 1'b0};
    if (v < MinSize) begin
      v = MinSize;
    end else if (v > max) begin
      v = max;
    end
    return v;
  endfunction

endpackage

[sv/rgb_to_yuv420_planar_core.sv]
// Top level of the BT.601 RGB888 to planar YUV 4:2:0 (I420) converter.
//
//  Channel   Direction  Payload
//  --------  ---------  --------------------------------------------------------
//  s_axis    in         tdata: red[7:0] green[15:8] blue[23:16]
//  m_axis    out        tdata: luma, luma_addr, chroma_u, chroma_v, u_addr, v_addr
//                       tuser: chroma_valid   tlast: frame_last
//  cfg       in         index 0 frame_width, index 1 frame_height, 13-bit data
//
// One pixel per clock sustained while results are taken; a result passes through
// the input register, then conversion into the result register.
// Each stage advances when the stage behind it is empty or being drained, so a
// stalled result only holds the pipe once both registers are full.
// Reset clears the counters and valid flags and loads the 640x480 default size.
// Plane offsets are registered from the size registers, so they follow a size write once those have updated.
module rgb_to_yuv420_planar_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Pixel input
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [ryp_pkg::InDataW-1:0]    s_axis_tdata_i,   // red, green, blue
  // Result output
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // luma[7:0], luma_addr[31:8], chroma_u[39:32], chroma_v[47:40],
  // u_addr[72:48], v_addr[97:73], zero fill[103:98]
  output logic [ryp_pkg::OutDataW-1:0]   m_axis_tdata_o,
  output logic                           m_axis_tuser_o,   // chroma_valid
  output logic                           m_axis_tlast_o,   // frame_last
  // Configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ryp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ryp_pkg::SizeW-1:0]      cfg_data_i
);

  ryp_pkg::cfg_t cfg;
  ryp_pkg::pix_t pix;
  ryp_pkg::res_t res;
  logic          pix_valid;
  logic          pix_ready;

  // Size registers; effective (even, clamped) sizes are held.
  ryp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Capture the pixel with its raster position, advance the counters.
  ryp_pixel_pos u_pos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i),
    .cfg_i       (cfg),
    .pix_valid_o (pix_valid),
    .pix_ready_i (pix_ready),
    .pix_o       (pix)
  );

  // Convert color, form plane addresses, hold the result for transfer.
  ryp_convert u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_valid),
    .pix_ready_o (pix_ready),
    .pix_i       (pix),
    .cfg_i       (cfg),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  // Pack the result fields, lowest field first, zero fill to whole bytes.
  assign m_axis_tdata_o = {6'b0, res.v_addr, res.u_addr, res.chroma_v, res.chroma_u,
                           res.luma_addr, res.luma};
  assign m_axis_tuser_o = res.chroma_valid;
  assign m_axis_tlast_o = res.frame_last;

endmodule

[sv/ryp_cfg_regs.sv]
// Frame size registers and the derived plane offsets.
module ryp_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ryp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ryp_pkg::SizeW-1:0]    cfg_data_i,
  output ryp_pkg::cfg_t                cfg_o
);

  logic [ryp_pkg::SizeW-1:0]  width_q, width_d;
  logic [ryp_pkg::SizeW-1:0]  height_q, height_d;
  logic [ryp_pkg::CAddrW-1:0] plane_u_q, plane_u_d;
  logic [ryp_pkg::CAddrW-1:0] plane_v_q, plane_v_d;
  logic [2*ryp_pkg::SizeW-1:0] area;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == ryp_pkg::RegFrameWidth) begin
        width_d = ryp_pkg::eff_size(cfg_data_i, ryp_pkg::MaxWidthC);
      end else if (cfg_index_i == ryp_pkg::RegFrameHeight) begin
        height_d = ryp_pkg::eff_size(cfg_data_i, ryp_pkg::MaxHeightC);
      end
    end
    area      = (2*ryp_pkg::SizeW)'(width_q) * (2*ryp_pkg::SizeW)'(height_q);
    plane_u_d = area[ryp_pkg::CAddrW-1:0];
    plane_v_d = plane_u_d + (plane_u_d >> 2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= ryp_pkg::WidthRst;
      height_q  <= ryp_pkg::HeightRst;
      plane_u_q <= '0;
      plane_v_q <= '0;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      plane_u_q <= plane_u_d;
      plane_v_q <= plane_v_d;
    end
  end

  assign cfg_o.width   = width_q;
  assign cfg_o.height  = height_q;
  assign cfg_o.plane_u = plane_u_q;
  assign cfg_o.plane_v = plane_v_q;

endmodule

[sv/ryp_pixel_pos.sv]
// Input register stage: pixel capture plus column and row counters.
module ryp_pixel_pos (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ryp_pkg::InDataW-1:0]   in_data_i,
  input  ryp_pkg::cfg_t                 cfg_i,
  output logic                          pix_valid_o,
  input  logic                          pix_ready_i,
  output ryp_pkg::pix_t                 pix_o
);

  logic [ryp_pkg::CntW-1:0] col_q, col_d;
  logic [ryp_pkg::CntW-1:0] row_q, row_d;
  logic                     valid_q, valid_d;
  ryp_pkg::pix_t            pix_q, pix_d;
  logic                     accept;
  logic                     end_row;
  logic                     end_frame;

  assign in_ready_o = !valid_q || pix_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    // A counter at or past a shrunk limit counts as the end of its row or frame.
    end_row   = {1'b0, col_q} >= (cfg_i.width - ryp_pkg::SizeW'(1));
    end_frame = end_row && ({1'b0, row_q} >= (cfg_i.height - ryp_pkg::SizeW'(1)));

    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (end_row) begin
        col_d = '0;
        row_d = end_frame ? '0 : row_q + ryp_pkg::CntW'(1);
      end else begin
        col_d = col_q + ryp_pkg::CntW'(1);
      end
    end

    valid_d = accept || (valid_q && !pix_ready_i);

    pix_d        = pix_q;
    if (accept) begin
      pix_d.red    = in_data_i[7:0];
      pix_d.green  = in_data_i[15:8];
      pix_d.blue   = in_data_i[23:16];
      pix_d.col    = col_q;
      pix_d.row    = row_q;
      pix_d.chroma = !col_q[0] && !row_q[0];
      pix_d.last   = end_frame;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

  assign pix_valid_o = valid_q;
  assign pix_o       = pix_q;

`include "rgb_to_yuv420_planar_core_macros.svh"

  `RYP_ASSERT(a_frame_wrap, (accept && end_frame) |=> (col_q == '0 && row_q == '0), "counters did not wrap after last pixel")
  `RYP_ASSERT(a_stage_hold, (valid_q && !pix_ready_i) |=> (valid_q && $stable(pix_q)), "input stage lost a stalled pixel")

endmodule

[sv/ryp_convert.sv]
// Color conversion and address generation into the result register.
module ryp_convert (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pix_valid_i,
  output logic           pix_ready_o,
  input  ryp_pkg::pix_t  pix_i,
  input  ryp_pkg::cfg_t  cfg_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output ryp_pkg::res_t  res_o
);

  logic                         valid_q, valid_d;
  ryp_pkg::res_t                res_q, res_d;
  logic                         take;
  logic [15:0]                  y_sum;
  logic [16:0]                  u_sum;
  logic [16:0]                  v_sum;
  logic [2*ryp_pkg::SizeW-2:0]  row_off;
  logic [2*ryp_pkg::SizeW-3:0]  c_off;
  logic [ryp_pkg::CAddrW-1:0]   c_idx;

  assign pix_ready_o = !valid_q || res_ready_i;
  assign take        = pix_valid_i && pix_ready_o;

  always_comb begin
    y_sum = 16'(pix_i.red) * 16'(ryp_pkg::CoefYR)
          + 16'(pix_i.green) * 16'(ryp_pkg::CoefYG)
          + 16'(pix_i.blue) * 16'(ryp_pkg::CoefYB)
          + 16'(ryp_pkg::RoundC);
    // Bias keeps both sums positive, so modulo arithmetic gives the floor shift.
    u_sum = 17'(pix_i.blue) * 17'(ryp_pkg::CoefUB) + ryp_pkg::ChromaBias
          - 17'(pix_i.red) * 17'(ryp_pkg::CoefUR)
          - 17'(pix_i.green) * 17'(ryp_pkg::CoefUG);
    v_sum = 17'(pix_i.red) * 17'(ryp_pkg::CoefVR) + ryp_pkg::ChromaBias
          - 17'(pix_i.green) * 17'(ryp_pkg::CoefVG)
          - 17'(pix_i.blue) * 17'(ryp_pkg::CoefVB);

    row_off = (2*ryp_pkg::SizeW-1)'(pix_i.row) * (2*ryp_pkg::SizeW-1)'(cfg_i.width)
            + (2*ryp_pkg::SizeW-1)'(pix_i.col);
    c_off   = (2*ryp_pkg::SizeW-2)'(pix_i.row[ryp_pkg::CntW-1:1])
            * (2*ryp_pkg::SizeW-2)'(cfg_i.width[ryp_pkg::SizeW-1:1])
            + (2*ryp_pkg::SizeW-2)'(pix_i.col[ryp_pkg::CntW-1:1]);
    c_idx   = ryp_pkg::CAddrW'(c_off);

    res_d = res_q;
    if (take) begin
      res_d.luma         = y_sum[15:8] + ryp_pkg::LumaOffset;
      res_d.luma_addr    = row_off[ryp_pkg::LAddrW-1:0];
      res_d.chroma_valid = pix_i.chroma;
      res_d.chroma_u     = pix_i.chroma ? u_sum[15:8] : '0;
      res_d.chroma_v     = pix_i.chroma ? v_sum[15:8] : '0;
      res_d.u_addr       = pix_i.chroma ? cfg_i.plane_u + c_idx : '0;
      res_d.v_addr       = pix_i.chroma ? cfg_i.plane_v + c_idx : '0;
      res_d.frame_last   = pix_i.last;
    end

    valid_d = take || (valid_q && !res_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

`include "rgb_to_yuv420_planar_core_macros.svh"

  `RYP_ASSERT(a_luma_range, valid_q |-> (res_q.luma >= 8'd16 && res_q.luma <= 8'd235), "luma out of range")
  `RYP_ASSERT_NEVER(a_stray_chroma, valid_q && !res_q.chroma_valid && (res_q.chroma_u != '0 || res_q.chroma_v != '0 || res_q.u_addr != '0 || res_q.v_addr != '0), "chroma fields set without chroma")
  `RYP_ASSERT(a_plane_order, (valid_q && res_q.chroma_valid) |-> (res_q.v_addr > res_q.u_addr), "V sample not above U sample")

endmodule
